/* rtl/tsis_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch slider smoother package
// Shared widths, constants and the configuration register bundle.
// ----------------------------------------------------------------------------
package tsis_pkg;

  localparam int unsigned PosWidth   = 16;
  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned RunWidth   = 4;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned CfgIdxWidth = 2;

  // Position code that means the slider is not touched (input) or off (output).
  localparam logic [PosWidth-1:0] NoTouch = 16'hFFFF;
  localparam logic [PosWidth-1:0] PosMax  = 16'd100;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxWidth-1:0] CfgKeepIdx    = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgNewIdx     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgReleaseIdx = 2'd2;

  // Reset values of the registers.
  localparam logic signed [CoefWidth-1:0] KeepReset    = 16'sd15401;
  localparam logic signed [CoefWidth-1:0] NewReset     = 16'sd983;
  localparam logic [RunWidth-1:0]         ReleaseReset = 4'd3;

  typedef struct packed {
    logic signed [CoefWidth-1:0] keep_coef;
    logic signed [CoefWidth-1:0] new_coef;
    logic [RunWidth-1:0]         release_frames;
  } cfg_t;

endpackage
`default_nettype wire

/* rtl/tsis_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch slider smoother configuration registers
// Holds the filter weights and the release limit written over the plain
// write port. Writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module tsis_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [tsis_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [tsis_pkg::CoefWidth-1:0]     cfg_data_i,
  output tsis_pkg::cfg_t                          cfg_o
);

  tsis_pkg::cfg_t cfg_q, cfg_d;

  // Next register contents for one write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsis_pkg::CfgKeepIdx:    cfg_d.keep_coef      = $signed(cfg_data_i);
        tsis_pkg::CfgNewIdx:     cfg_d.new_coef       = $signed(cfg_data_i);
        tsis_pkg::CfgReleaseIdx: cfg_d.release_frames = cfg_data_i[tsis_pkg::RunWidth-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  // Register bank with its reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.keep_coef      <= tsis_pkg::KeepReset;
      cfg_q.new_coef       <= tsis_pkg::NewReset;
      cfg_q.release_frames <= tsis_pkg::ReleaseReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* rtl/tsis_filter_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch slider smoother filter core
// Holds the tracking state and computes one smoothed position per request:
// pass-through on the first touch, Q14 single-pole low pass with clamp on
// later touches, hold and release on no-touch frames.
// ----------------------------------------------------------------------------
module tsis_filter_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire tsis_pkg::cfg_t                   cfg_i,
  input  wire logic                             step_i,
  input  wire logic [tsis_pkg::PosWidth-1:0]    raw_i,
  output logic      [tsis_pkg::PosWidth-1:0]    result_o
);

  logic [tsis_pkg::PosWidth-1:0] last_q, last_d;
  logic                          tracking_q, tracking_d;
  logic [tsis_pkg::RunWidth-1:0] off_run_q, off_run_d;

  logic signed [32:0] prod_keep;
  logic signed [32:0] prod_new;
  logic signed [33:0] acc;
  logic signed [19:0] filt;
  logic [tsis_pkg::PosWidth-1:0] clamped;
  logic [tsis_pkg::RunWidth-1:0] run_inc;

  // Both weighted terms; positions are unsigned, so they get a zero sign bit.
  assign prod_keep = $signed({1'b0, last_q}) * cfg_i.keep_coef;
  assign prod_new  = $signed({1'b0, raw_i}) * cfg_i.new_coef;
  assign acc       = 34'(prod_keep) + 34'(prod_new);

  // Dropping the low fraction bits of a two's complement value is a floor.
  assign filt = acc[33:tsis_pkg::FracBits];

  // Clamp the filtered value into the valid position range.
  always_comb begin
    if (filt < 20'sd0) begin
      clamped = '0;
    end else if (filt > $signed({4'd0, tsis_pkg::PosMax})) begin
      clamped = tsis_pkg::PosMax;
    end else begin
      clamped = filt[tsis_pkg::PosWidth-1:0];
    end
  end

  assign run_inc = off_run_q + 4'd1;

  // Result and next state for the request in the input register.
  always_comb begin
    last_d     = last_q;
    tracking_d = tracking_q;
    off_run_d  = off_run_q;
    result_o   = tsis_pkg::NoTouch;
    if (raw_i == tsis_pkg::NoTouch) begin
      if (tracking_q) begin
        if (run_inc < cfg_i.release_frames) begin
          off_run_d = run_inc;
          result_o  = last_q;
        end else begin
          // Release limit reached: tracking ends and the output turns off.
          off_run_d  = '0;
          tracking_d = 1'b0;
        end
      end
    end else begin
      off_run_d  = '0;
      tracking_d = 1'b1;
      if (tracking_q) begin
        last_d = clamped;
      end else begin
        last_d = raw_i;
      end
      result_o = last_d;
    end
  end

  // State advances only when the request moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      tracking_q <= 1'b0;
      off_run_q  <= '0;
    end else if (step_i) begin
      last_q     <= last_d;
      tracking_q <= tracking_d;
      off_run_q  <= off_run_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/touch_slider_iir_smoother.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch slider IIR smoother
// Smooths raw slider positions with a Q14 single-pole low pass, with
// pass-through on first touch and a release count for no-touch frames.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// s_axis    in         s_axis_tvalid/tready     tdata[15:0] raw_position
// m_axis    out        m_axis_tvalid/tready     tdata[15:0] smoothed_position
// cfg       in         cfg_we_i (no wait)       cfg_index_i, cfg_data_i
//
// One request per cycle is sustained. A request waits in the input register,
// where both products, the sum and the clamp are computed, until the result
// register is free or being read, then sits in the result register until taken.
// The input is stalled only while both registers are full and m_axis_tready
// is low. Reset clears the valid flags and the filter state, not the data.
// ----------------------------------------------------------------------------
module touch_slider_iir_smoother (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Input stream: tdata = raw_position[15:0]
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  input  wire logic [tsis_pkg::PosWidth-1:0]        s_axis_tdata,
  // Output stream: tdata = smoothed_position[15:0]
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  output logic      [tsis_pkg::PosWidth-1:0]        m_axis_tdata,
  // Configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [tsis_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  wire logic [tsis_pkg::CoefWidth-1:0]       cfg_data_i
);

  tsis_pkg::cfg_t cfg;

  logic                          in_valid_q;
  logic [tsis_pkg::PosWidth-1:0] in_raw_q;
  logic                          out_valid_q;
  logic [tsis_pkg::PosWidth-1:0] out_data_q;
  logic [tsis_pkg::PosWidth-1:0] result;
  logic                          advance;
  logic                          in_fire;

  tsis_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // The request moves on whenever the result register is free or being read.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  tsis_filter_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .raw_i    (in_raw_q),
    .result_o (result)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_raw_q <= s_axis_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

/* rtl/tsis_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Touch slider smoother port checker
// Watches the top-level ports for stall behavior and result latency.
// ----------------------------------------------------------------------------
module tsis_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                s_axis_tvalid,
  input wire logic                                s_axis_tready,
  input wire logic                                m_axis_tvalid,
  input wire logic                                m_axis_tready,
  input wire logic [tsis_pkg::PosWidth-1:0]       m_axis_tdata
);

  // The input side stalls only because the output side is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  // A request taken with output empty passes the input and result registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !m_axis_tvalid) |-> ##2 m_axis_tvalid)
    else $error("result missing two cycles after request");

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind touch_slider_iir_smoother tsis_checker u_tsis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
